@@ sv/gtg_pkg.sv @@
package gtg_pkg;

    localparam int ZW = 34;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROBOT_NUMBER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_X        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_CHECK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD    = 3'd5;

    localparam logic                 ACT_DIRECTIVE      = 1'b0;

    localparam int PI_Q13        = 25736;
    localparam int TWO_PI_Q13    = 51472;
    localparam int HALF_PI_Q13   = 12868;
    localparam logic signed [ZW-1:0] PI_Q30       = 34'sd3373259426;
    localparam logic signed [ZW-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam int ARRIVE_SQ_MM  = 3600;
    localparam int NEAR_LIMIT_MM = 1024;
    localparam int ONE_Q14       = 16384;

    // floor(n / 1000) = (n * RECIP_1000) >> 36 for n < 2^26
    localparam logic [26:0] RECIP_1000 = 27'd68719477;
    // floor(n / 5) = (n * RECIP_5) >> 24 for n < 2^20
    localparam logic [26:0] RECIP_5    = 27'd3355444;

    localparam int SQ_IN_W  = 29;
    localparam int SQ_OUT_W = 15;

    typedef struct packed {
        logic start;
        logic rotate;
    } cordic_ctl_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        case (idx)
            5'd0:    return 34'sd843314857;
            5'd1:    return 34'sd497837829;
            5'd2:    return 34'sd263043837;
            5'd3:    return 34'sd133525159;
            5'd4:    return 34'sd67021687;
            5'd5:    return 34'sd33543516;
            5'd6:    return 34'sd16775851;
            5'd7:    return 34'sd8388437;
            5'd8:    return 34'sd4194283;
            5'd9:    return 34'sd2097149;
            5'd10:   return 34'sd1048576;
            5'd11:   return 34'sd524288;
            5'd12:   return 34'sd262144;
            5'd13:   return 34'sd131072;
            5'd14:   return 34'sd65536;
            5'd15:   return 34'sd32768;
            5'd16:   return 34'sd16384;
            5'd17:   return 34'sd8192;
            5'd18:   return 34'sd4096;
            5'd19:   return 34'sd2048;
            5'd20:   return 34'sd1024;
            5'd21:   return 34'sd512;
            5'd22:   return 34'sd256;
            5'd23:   return 34'sd128;
            default: return '0;
        endcase
    endfunction

endpackage

@@ sv/gtg_cordic.sv @@
module gtg_cordic #(
    parameter int DW    = 33,
    parameter int STEPS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gtg_pkg::cordic_ctl_t            ctl,
    input  logic signed [DW-1:0]            x_in,
    input  logic signed [DW-1:0]            y_in,
    input  logic signed [gtg_pkg::ZW-1:0]   z_in,
    output logic                            busy,
    output logic signed [DW-1:0]            x_out,
    output logic signed [gtg_pkg::ZW-1:0]   z_out
);

    localparam int NSTEP = (STEPS < 24) ? STEPS : 24;
    localparam int IW    = $clog2(NSTEP + 1);

    logic [IW-1:0]                  iter_reg;
    logic                           busy_reg;
    logic                           rotate_reg;
    logic signed [DW-1:0]           x_reg;
    logic signed [DW-1:0]           y_reg;
    logic signed [gtg_pkg::ZW-1:0]  z_reg;

    logic signed [DW-1:0]           xs;
    logic signed [DW-1:0]           ys;
    logic signed [gtg_pkg::ZW-1:0]  ang;
    logic                           dir_pos;

    always_comb
    begin
        xs      = x_reg >>> iter_reg;
        ys      = y_reg >>> iter_reg;
        ang     = gtg_pkg::atan_q30(5'(iter_reg));
        dir_pos = rotate_reg ? !z_reg[gtg_pkg::ZW-1] : !(y_reg > 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            iter_reg <= '0;
        end
        else if (busy_reg)
        begin
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == IW'(NSTEP - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rotate_reg <= ctl.rotate;
            x_reg      <= x_in;
            y_reg      <= y_in;
            z_reg      <= z_in;
        end
        else if (busy_reg)
        begin
            if (dir_pos)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang;
            end
        end
    end

    assign busy  = busy_reg;
    assign x_out = x_reg;
    assign z_out = z_reg;

endmodule

@@ sv/gtg_isqrt.sv @@
module gtg_isqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [gtg_pkg::SQ_IN_W-1:0]     value,
    output logic                            busy,
    output logic [gtg_pkg::SQ_OUT_W-1:0]    root
);

    localparam int W = gtg_pkg::SQ_IN_W;

    logic [W-1:0] bit_reg;
    logic [W-1:0] v_reg;
    logic [W-1:0] r_reg;
    logic [W:0]   trial;

    assign trial = {1'b0, r_reg} + {1'b0, bit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '0;
        end
        else if (start)
        begin
            bit_reg <= W'(1) << (W - 1);
        end
        else
        begin
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= value;
            r_reg <= '0;
        end
        else if (bit_reg != '0)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_reg <= v_reg - trial[W-1:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
        end
    end

    assign busy = (bit_reg != '0);
    assign root = r_reg[gtg_pkg::SQ_OUT_W-1:0];

endmodule

@@ sv/go_to_goal_steer_with_link_watchdog_unit.sv @@
// Directive request: taken while idle, gives no result.
// Tick request: watchdog check first, and a frozen result goes straight out; otherwise the
// distance, and within 1024 mm either arrival (zero result) or a 15-step isqrt speed scale;
// then operand normalization, CORDIC atan, heading error, turn and, if aligned, CORDIC cosine.
// One request at a time; the next is taken once the result is handed off.
// Reset (async, active low) clears the watchdog, goal and config to defaults.
module go_to_goal_steer_with_link_watchdog_unit #(
    parameter int  COORD_WIDTH  = 16,
    parameter int  CORDIC_STEPS = 16,
    localparam int CfgW         = (COORD_WIDTH > 16) ? COORD_WIDTH : 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [CfgW-1:0]                     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic                                well_formed,
    input  logic [7:0]                          addressed_robot,
    input  logic                                link_blocked,
    input  logic signed [COORD_WIDTH-1:0]       directive_x,
    input  logic signed [COORD_WIDTH-1:0]       directive_y,
    input  logic signed [COORD_WIDTH-1:0]       position_x,
    input  logic signed [COORD_WIDTH-1:0]       position_y,
    input  logic signed [15:0]                  heading,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [15:0]                  turn_rate,
    output logic [14:0]                         forward_speed,
    output logic                                frozen
);

    localparam int EW = COORD_WIDTH + 1;
    localparam int DW = (COORD_WIDTH + 3 > 33) ? COORD_WIDTH + 3 : 33;
    localparam int ZW = gtg_pkg::ZW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WDOG  = 4'd1;
    localparam logic [3:0] S_DIST  = 4'd2;
    localparam logic [3:0] S_SQ2   = 4'd3;
    localparam logic [3:0] S_SQ3   = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_ATSET = 4'd7;
    localparam logic [3:0] S_NORM  = 4'd8;
    localparam logic [3:0] S_ATAN  = 4'd9;
    localparam logic [3:0] S_ERR   = 4'd10;
    localparam logic [3:0] S_TURN1 = 4'd11;
    localparam logic [3:0] S_TURN2 = 4'd12;
    localparam logic [3:0] S_COS   = 4'd13;
    localparam logic [3:0] S_SPD   = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [3:0]                     state_reg;
    logic [3:0]                     state_next;

    logic [7:0]                     robot_reg;
    logic                           lce_reg;
    logic [15:0]                    timeout_reg;
    logic [9:0]                     period_reg;

    logic signed [COORD_WIDTH-1:0]  goal_x_reg;
    logic signed [COORD_WIDTH-1:0]  goal_y_reg;
    logic                           heard_reg;
    logic                           pending_reg;
    logic [31:0]                    elapsed_reg;
    logic [31:0]                    last_reg;

    logic signed [COORD_WIDTH-1:0]  posx_reg;
    logic signed [COORD_WIDTH-1:0]  posy_reg;
    logic signed [15:0]             head_reg;
    logic signed [EW-1:0]           ex_reg;
    logic signed [EW-1:0]           ey_reg;
    logic [19:0]                    d2a_reg;
    logic [14:0]                    s_reg;
    logic signed [DW-1:0]           xn_reg;
    logic signed [DW-1:0]           yn_reg;
    logic signed [ZW-1:0]           zn_reg;
    logic signed [17:0]             atan_reg;
    logic signed [15:0]             e_reg;
    logic [53:0]                    prod_reg;
    logic signed [15:0]             turn_reg;
    logic [14:0]                    speed_reg;
    logic                           frozen_reg;

    logic                           in_acc;
    logic                           dir_ok;
    logic                           fresh;
    logic [31:0]                    elapsed_sum;
    logic                           wd_frozen;
    logic [EW-1:0]                  abs_ex;
    logic [EW-1:0]                  abs_ey;
    logic                           far;
    logic [20:0]                    d2;
    logic [25:0]                    num1000;
    logic [17:0]                    s_div;
    logic [14:0]                    s_val;
    logic signed [DW-1:0]           ayn;
    logic signed [DW-1:0]           mn;
    logic                           n_small;
    logic                           n_zero;
    logic signed [DW-1:0]           exw;
    logic signed [DW-1:0]           eyw;
    logic [ZW-1:0]                  zabs;
    logic [ZW-1:0]                  zr;
    logic signed [17:0]             atan_q13;
    logic signed [18:0]             e_raw;
    logic signed [18:0]             e_w;
    logic [14:0]                    e_abs;
    logic [18:0]                    t_abs;
    logic [19:0]                    n5;
    logic [19:0]                    tmag;
    logic [15:0]                    tclamp;
    logic                           aligned;
    logic signed [DW-1:0]           c_sum;
    logic signed [DW-1:0]           c_sh;
    logic [14:0]                    c_val;
    logic [15:0]                    sp;
    logic [26:0]                    mul_a;
    logic [26:0]                    mul_b;

    gtg_pkg::cordic_ctl_t           cd_ctl;
    logic signed [DW-1:0]           cd_x_in;
    logic signed [DW-1:0]           cd_y_in;
    logic signed [ZW-1:0]           cd_z_in;
    logic                           cd_busy;
    logic signed [DW-1:0]           cd_x;
    logic signed [ZW-1:0]           cd_z;

    logic                           sq_start;
    logic                           sq_busy;
    logic [gtg_pkg::SQ_OUT_W-1:0]   sq_root;

    gtg_cordic #(
        .DW    (DW),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cd_ctl),
        .x_in  (cd_x_in),
        .y_in  (cd_y_in),
        .z_in  (cd_z_in),
        .busy  (cd_busy),
        .x_out (cd_x),
        .z_out (cd_z)
    );

    gtg_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value ({d2, 8'b0}),
        .busy  (sq_busy),
        .root  (sq_root)
    );

    always_comb
    begin
        in_acc      = in_valid && (state_reg == S_IDLE);
        dir_ok      = well_formed && (addressed_robot == robot_reg)
                      && !(lce_reg && link_blocked);
        fresh       = !heard_reg && !pending_reg;
        elapsed_sum = elapsed_reg + {22'b0, period_reg};
        wd_frozen   = !heard_reg || ((elapsed_reg - last_reg) > {16'b0, timeout_reg});

        abs_ex  = ex_reg[EW-1] ? EW'(-ex_reg) : ex_reg;
        abs_ey  = ey_reg[EW-1] ? EW'(-ey_reg) : ey_reg;
        far     = (abs_ex >= EW'(gtg_pkg::NEAR_LIMIT_MM))
                  || (abs_ey >= EW'(gtg_pkg::NEAR_LIMIT_MM));
        d2      = {1'b0, d2a_reg} + {1'b0, prod_reg[19:0]};
        num1000 = ({11'b0, sq_root} << 10) + ({11'b0, sq_root} << 9) + 26'd500;
        s_div   = prod_reg[53:36];
        s_val   = (s_div > 18'(gtg_pkg::ONE_Q14)) ? 15'(gtg_pkg::ONE_Q14) : s_div[14:0];

        ayn     = yn_reg[DW-1] ? -yn_reg : yn_reg;
        mn      = (xn_reg > ayn) ? xn_reg : ayn;
        n_zero  = (mn == '0);
        n_small = (mn < (DW'(1) <<< 29));
        exw     = DW'(ex_reg);
        eyw     = DW'(ey_reg);

        zabs     = cd_z[ZW-1] ? ZW'(-cd_z) : ZW'(cd_z);
        zr       = (zabs + ZW'(65536)) >> 17;
        atan_q13 = cd_z[ZW-1] ? -18'(zr) : 18'(zr);

        e_raw = {atan_reg[17], atan_reg} - 19'(head_reg);
        if (e_raw > gtg_pkg::PI_Q13)
        begin
            e_w = 19'(e_raw - gtg_pkg::TWO_PI_Q13);
        end
        else if (e_raw < -gtg_pkg::PI_Q13)
        begin
            e_w = 19'(e_raw + gtg_pkg::TWO_PI_Q13);
        end
        else
        begin
            e_w = e_raw;
        end

        e_abs   = e_reg[15] ? 15'(-e_reg) : e_reg[14:0];
        t_abs   = ({4'b0, e_abs} << 4) - ({4'b0, e_abs} << 1);
        n5      = {1'b0, t_abs} + 20'd2;
        tmag    = prod_reg[43:24];
        tclamp  = (tmag > 20'(gtg_pkg::ONE_Q14)) ? 16'(gtg_pkg::ONE_Q14) : tmag[15:0];
        aligned = (e_abs < 15'(gtg_pkg::HALF_PI_Q13));

        c_sum = cd_x + DW'(32768);
        c_sh  = c_sum >>> 16;
        c_val = (c_sh > DW'(gtg_pkg::ONE_Q14)) ? 15'(gtg_pkg::ONE_Q14) : c_sh[14:0];
        sp    = 16'((prod_reg[29:0] + 30'd8192) >> 14);

        cd_ctl.start  = ((state_reg == S_NORM) && !n_zero && !n_small)
                        || ((state_reg == S_TURN2) && aligned);
        cd_ctl.rotate = (state_reg == S_TURN2);
        if (state_reg == S_TURN2)
        begin
            cd_x_in = DW'(gtg_pkg::INV_GAIN_Q30);
            cd_y_in = '0;
            cd_z_in = {e_reg[15], e_reg, 17'b0};
        end
        else
        begin
            cd_x_in = xn_reg;
            cd_y_in = yn_reg;
            cd_z_in = zn_reg;
        end

        sq_start = (state_reg == S_SQ3) && (d2 > 21'(gtg_pkg::ARRIVE_SQ_MM));

        case (state_reg)
            S_DIST:
            begin
                mul_a = {17'b0, abs_ex[9:0]};
                mul_b = {17'b0, abs_ex[9:0]};
            end
            S_SQ2:
            begin
                mul_a = {17'b0, abs_ey[9:0]};
                mul_b = {17'b0, abs_ey[9:0]};
            end
            S_SQRT:
            begin
                mul_a = {1'b0, num1000};
                mul_b = gtg_pkg::RECIP_1000;
            end
            S_TURN1:
            begin
                mul_a = {7'b0, n5};
                mul_b = gtg_pkg::RECIP_5;
            end
            S_COS:
            begin
                mul_a = {12'b0, s_reg};
                mul_b = {12'b0, c_val};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid && action != gtg_pkg::ACT_DIRECTIVE) state_next = S_WDOG;
            S_WDOG:  state_next = wd_frozen ? S_OUT : S_DIST;
            S_DIST:  state_next = far ? S_ATSET : S_SQ2;
            S_SQ2:   state_next = S_SQ3;
            S_SQ3:   state_next = sq_start ? S_SQRT : S_OUT;
            S_SQRT:  if (!sq_busy) state_next = S_DIV;
            S_DIV:   state_next = S_ATSET;
            S_ATSET: state_next = S_NORM;
            S_NORM:
            begin
                if (n_zero)
                begin
                    state_next = S_ERR;
                end
                else if (!n_small)
                begin
                    state_next = S_ATAN;
                end
            end
            S_ATAN:  if (!cd_busy) state_next = S_ERR;
            S_ERR:   state_next = S_TURN1;
            S_TURN1: state_next = S_TURN2;
            S_TURN2: state_next = aligned ? S_COS : S_OUT;
            S_COS:
            begin
                if (!cd_busy)
                begin
                    state_next = (cd_x > 0) ? S_SPD : S_OUT;
                end
            end
            S_SPD:   state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            robot_reg   <= '0;
            lce_reg     <= 1'b0;
            timeout_reg <= 16'd500;
            period_reg  <= 10'd100;
            goal_x_reg  <= '0;
            goal_y_reg  <= '0;
            heard_reg   <= 1'b0;
            pending_reg <= 1'b0;
            elapsed_reg <= '0;
            last_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    gtg_pkg::REG_ROBOT_NUMBER: robot_reg <= cfg_data[7:0];
                    gtg_pkg::REG_START_X:
                    begin
                        if (fresh) goal_x_reg <= $signed(cfg_data[COORD_WIDTH-1:0]);
                    end
                    gtg_pkg::REG_START_Y:
                    begin
                        if (fresh) goal_y_reg <= $signed(cfg_data[COORD_WIDTH-1:0]);
                    end
                    gtg_pkg::REG_LINK_CHECK:   lce_reg     <= cfg_data[0];
                    gtg_pkg::REG_TIMEOUT:      timeout_reg <= cfg_data[15:0];
                    gtg_pkg::REG_TICK_PERIOD:  period_reg  <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (in_acc)
            begin
                if (action == gtg_pkg::ACT_DIRECTIVE)
                begin
                    if (dir_ok)
                    begin
                        goal_x_reg  <= directive_x;
                        goal_y_reg  <= directive_y;
                        pending_reg <= 1'b1;
                    end
                end
                else
                begin
                    elapsed_reg <= elapsed_sum;
                    if (pending_reg)
                    begin
                        last_reg    <= elapsed_sum;
                        heard_reg   <= 1'b1;
                        pending_reg <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                posx_reg <= position_x;
                posy_reg <= position_y;
                head_reg <= heading;
            end
            S_WDOG:
            begin
                ex_reg     <= EW'(goal_x_reg) - EW'(posx_reg);
                ey_reg     <= EW'(goal_y_reg) - EW'(posy_reg);
                frozen_reg <= wd_frozen;
                turn_reg   <= '0;
                speed_reg  <= '0;
            end
            S_DIST:  if (far) s_reg <= 15'(gtg_pkg::ONE_Q14);
            S_SQ2:   d2a_reg <= prod_reg[19:0];
            S_DIV:   s_reg <= s_val;
            S_ATSET:
            begin
                if (ex_reg[EW-1])
                begin
                    xn_reg <= -exw;
                    yn_reg <= -eyw;
                    zn_reg <= ey_reg[EW-1] ? -gtg_pkg::PI_Q30 : gtg_pkg::PI_Q30;
                end
                else
                begin
                    xn_reg <= exw;
                    yn_reg <= eyw;
                    zn_reg <= '0;
                end
            end
            S_NORM:
            begin
                if (n_zero)
                begin
                    atan_reg <= '0;
                end
                else if (n_small)
                begin
                    xn_reg <= xn_reg <<< 1;
                    yn_reg <= yn_reg <<< 1;
                end
            end
            S_ATAN:  if (!cd_busy) atan_reg <= atan_q13;
            S_ERR:   e_reg <= e_w[15:0];
            S_TURN2: turn_reg <= e_reg[15] ? -$signed(tclamp) : $signed(tclamp);
            S_SPD:   speed_reg <= (sp > 16'(gtg_pkg::ONE_Q14)) ? 15'(gtg_pkg::ONE_Q14) : sp[14:0];
            default: ;
        endcase
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign turn_rate     = turn_reg;
    assign forward_speed = speed_reg;
    assign frozen        = frozen_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while result pending");

    a_frozen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frozen) |-> (turn_rate == 16'sd0 && forward_speed == 15'd0))
        else $error("frozen result carries motion");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (forward_speed <= 15'(gtg_pkg::ONE_Q14)
                       && turn_rate >= -16'sd16384 && turn_rate <= 16'sd16384))
        else $error("command out of range");

    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result repeated");

    a_heard_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && action != gtg_pkg::ACT_DIRECTIVE && pending_reg) |=> heard_reg && !pending_reg)
        else $error("pending directive not stamped");

endmodule

@@ sim/tb_go_to_goal_steer_with_link_watchdog_unit.sv @@
`timescale 1ns / 100ps

module tb_go_to_goal_steer_with_link_watchdog_unit;

    localparam int STEPS = 16;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [gtg_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [gtg_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic ACT_TICK = ~gtg_pkg::ACT_DIRECTIVE;

    typedef struct {
        logic act;
        logic wf;
        logic [7:0] rob;
        logic blk;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] hd;
    } request_t;

    typedef struct {
        logic signed [15:0] turn;
        logic [14:0] speed;
        logic frz;
    } drive_cmd_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [gtg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic action;
    logic well_formed;
    logic [7:0] addressed_robot;
    logic link_blocked;
    logic signed [15:0] directive_x;
    logic signed [15:0] directive_y;
    logic signed [15:0] position_x;
    logic signed [15:0] position_y;
    logic signed [15:0] heading;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] turn_rate;
    logic [14:0] forward_speed;
    logic frozen;

    go_to_goal_steer_with_link_watchdog_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .well_formed(well_formed), .addressed_robot(addressed_robot),
        .link_blocked(link_blocked), .directive_x(directive_x), .directive_y(directive_y),
        .position_x(position_x), .position_y(position_y), .heading(heading),
        .out_valid(out_valid), .out_stall(out_stall),
        .turn_rate(turn_rate), .forward_speed(forward_speed), .frozen(frozen)
    );

    // predictor state
    logic [7:0] my_id;
    logic signed [15:0] home_x, home_y, tgt_x, tgt_y;
    logic guard_on, heard, pend;
    logic [15:0] grace_ms;
    logic [9:0] step_ms;
    logic [31:0] clock_ms, last_ms;

    drive_cmd_t cmd_q[$];
    int errors;
    int cycles;
    bit idle_off;

    longint atan_tab[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL go_to_goal_steer_with_link_watchdog_unit");
            $finish;
        end
    end

    function automatic longint arctan_q13(longint y, longint x);
        longint z, m, k, nx, ny;
        z = 0;
        k = 1;
        if (x < 0)
        begin
            z = (y >= 0) ? longint'(gtg_pkg::PI_Q30) : -longint'(gtg_pkg::PI_Q30);
            x = -x;
            y = -y;
        end
        m = (y < 0) ? -y : y;
        if (x > m) m = x;
        if (m <= 0) return 0;
        while (m < 64'sd536870912)
        begin
            m = m * 2;
            k = k * 2;
        end
        x = x * k;
        y = y * k;
        for (int i = 0; i < STEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_tab[i];
            end
            else
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_tab[i];
            end
            x = nx;
            y = ny;
        end
        if (z >= 0) return (z + 65536) / 131072;
        return -((-z + 65536) / 131072);
    endfunction

    function automatic longint cosine_q14(longint e);
        longint x, y, z, nx, ny, c;
        x = longint'(gtg_pkg::INV_GAIN_Q30);
        y = 0;
        z = e * 131072;
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_tab[i];
            end
            else
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_tab[i];
            end
            x = nx;
            y = ny;
        end
        if (x <= 0) return 0;
        c = (x + 32768) >>> 16;
        return (c > gtg_pkg::ONE_Q14) ? gtg_pkg::ONE_Q14 : c;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic drive_cmd_t steer(logic signed [15:0] px, logic signed [15:0] py,
                                         logic signed [15:0] hd, logic frz);
        drive_cmd_t cmd;
        longint ex, ey, ax, ay, s, e, t, c, spd;
        bit moving;
        cmd.turn = '0;
        cmd.speed = '0;
        cmd.frz = frz;
        if (frz) return cmd;
        ex = longint'(tgt_x) - longint'(px);
        ey = longint'(tgt_y) - longint'(py);
        ax = (ex < 0) ? -ex : ex;
        ay = (ey < 0) ? -ey : ey;
        s = gtg_pkg::ONE_Q14;
        moving = 1'b1;
        if (ax < gtg_pkg::NEAR_LIMIT_MM && ay < gtg_pkg::NEAR_LIMIT_MM)
        begin
            if (ax * ax + ay * ay <= gtg_pkg::ARRIVE_SQ_MM)
                moving = 1'b0;
            else
            begin
                s = (int_sqrt((ax * ax + ay * ay) << 8) * 1536 + 500) / 1000;
                if (s > gtg_pkg::ONE_Q14) s = gtg_pkg::ONE_Q14;
            end
        end
        if (!moving) return cmd;
        e = arctan_q13(ey, ex) - longint'(hd);
        while (e > gtg_pkg::PI_Q13) e = e - gtg_pkg::TWO_PI_Q13;
        while (e < -gtg_pkg::PI_Q13) e = e + gtg_pkg::TWO_PI_Q13;
        t = e * 14;
        t = (t >= 0) ? (t + 2) / 5 : -((-t + 2) / 5);
        if (t > gtg_pkg::ONE_Q14) t = gtg_pkg::ONE_Q14;
        if (t < -gtg_pkg::ONE_Q14) t = -gtg_pkg::ONE_Q14;
        cmd.turn = t[15:0];
        if (e < gtg_pkg::HALF_PI_Q13 && e > -gtg_pkg::HALF_PI_Q13)
        begin
            c = cosine_q14(e);
            if (c > 0)
            begin
                spd = (s * c + 8192) >>> 14;
                if (spd > gtg_pkg::ONE_Q14) spd = gtg_pkg::ONE_Q14;
                cmd.speed = spd[14:0];
            end
        end
        return cmd;
    endfunction

    task automatic predict_request(request_t r);
        logic frz;
        if (r.act == gtg_pkg::ACT_DIRECTIVE)
        begin
            if (r.wf && r.rob == my_id && !(guard_on && r.blk))
            begin
                tgt_x = r.dx;
                tgt_y = r.dy;
                pend = 1'b1;
            end
            return;
        end
        clock_ms = clock_ms + 32'(step_ms);
        if (pend)
        begin
            last_ms = clock_ms;
            heard = 1'b1;
            pend = 1'b0;
        end
        frz = !heard || ((clock_ms - last_ms) > 32'(grace_ms));
        cmd_q.push_back(steer(r.px, r.py, r.hd, frz));
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker with its own stall pattern
    initial
    begin
        drive_cmd_t want;
        int w;
        forever
        begin
            w = idle_off ? 0 : $urandom_range(0, 19);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            if (cmd_q.size() == 0)
                report("unexpected result", frozen, 0);
            else
            begin
                want = cmd_q.pop_front();
                if (turn_rate !== want.turn) report("turn_rate", turn_rate, want.turn);
                if (forward_speed !== want.speed)
                    report("forward_speed", forward_speed, want.speed);
                if (frozen !== want.frz) report("frozen", frozen, want.frz);
            end
        end
    end

    // waits until no request is in flight before writing
    task automatic cfg_wr(logic [gtg_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        bit fresh;
        in_valid <= 1'b0;
        while (cmd_q.size() != 0) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        fresh = !heard && !pend;
        case (idx)
            gtg_pkg::REG_ROBOT_NUMBER: my_id = val[7:0];
            gtg_pkg::REG_START_X:
            begin
                home_x = val;
                if (fresh) tgt_x = home_x;
            end
            gtg_pkg::REG_START_Y:
            begin
                home_y = val;
                if (fresh) tgt_y = home_y;
            end
            gtg_pkg::REG_LINK_CHECK: guard_on = val[0];
            gtg_pkg::REG_TIMEOUT: grace_ms = val;
            gtg_pkg::REG_TICK_PERIOD: step_ms = val[9:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send(request_t r);
        int g;
        g = idle_off ? 0 : $urandom_range(0, 19);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= r.act;
        well_formed <= r.wf;
        addressed_robot <= r.rob;
        link_blocked <= r.blk;
        directive_x <= r.dx;
        directive_y <= r.dy;
        position_x <= r.px;
        position_y <= r.py;
        heading <= r.hd;
        do @(posedge clk); while (in_stall);
        predict_request(r);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (cmd_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic request_t make_dir(logic [7:0] rob, logic wf, logic blk,
                                          logic signed [15:0] x, logic signed [15:0] y);
        request_t r;
        r.act = gtg_pkg::ACT_DIRECTIVE;
        r.wf = wf;
        r.rob = rob;
        r.blk = blk;
        r.dx = x;
        r.dy = y;
        r.px = 16'($urandom);
        r.py = 16'($urandom);
        r.hd = 16'($urandom);
        return r;
    endfunction

    function automatic request_t make_tick(logic signed [15:0] px, logic signed [15:0] py,
                                           logic signed [15:0] hd);
        request_t r;
        r.act = ACT_TICK;
        r.wf = 1'($urandom);
        r.rob = 8'($urandom);
        r.blk = 1'($urandom);
        r.dx = 16'($urandom);
        r.dy = 16'($urandom);
        r.px = px;
        r.py = py;
        r.hd = hd;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_coord();
        if ($urandom_range(0, 9) < 3) return 16'($urandom);
        return 16'($signed($urandom_range(0, 4000)) - 2000);
    endfunction

    function automatic logic signed [15:0] rand_heading();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 2 * gtg_pkg::PI_Q13)) - gtg_pkg::PI_Q13);
    endfunction

    task automatic test_before_link();
        send(make_tick(16'sd500, -16'sd500, 16'sd0));
        cfg_wr(gtg_pkg::REG_START_X, 16'h8000);
        cfg_wr(gtg_pkg::REG_START_Y, 16'h7fff);
        send(make_dir(8'd1, 1'b1, 1'b0, 16'sd10, 16'sd10));
        send(make_dir(8'd0, 1'b0, 1'b0, 16'sd10, 16'sd10));
        send(make_tick(16'sd0, 16'sd0, 16'sd0));
        settle();
    endtask

    task automatic test_directed_steering();
        cfg_wr(gtg_pkg::REG_ROBOT_NUMBER, 16'd255);
        cfg_wr(gtg_pkg::REG_LINK_CHECK, 16'd1);
        cfg_wr(gtg_pkg::REG_TIMEOUT, 16'd65535);
        cfg_wr(gtg_pkg::REG_TICK_PERIOD, 16'd1000);
        send(make_dir(8'd255, 1'b1, 1'b1, 16'sd100, 16'sd100));
        send(make_dir(8'd255, 1'b1, 1'b0, 16'sh7fff, 16'sh8000));
        send(make_tick(16'sh8000, 16'sh7fff, 16'sd25736));
        send(make_tick(16'sh7fff, 16'sh8000, -16'sd25736));
        send(make_tick(16'sh7fff, -16'sd32708, 16'sd0));
        send(make_tick(16'sh7fff, -16'sd32000, 16'sh8000));
        send(make_tick(16'sh7fff - 16'sd300, 16'sh8000 + 16'sd200, 16'sh7fff));
        send(make_tick(16'sh7fff - 16'sd1023, 16'sh8000, 16'sd12868));
        send(make_tick(16'sh7fff, 16'sh8000 + 16'sd61, -16'sd12867));
        cfg_wr(gtg_pkg::REG_LINK_CHECK, 16'd0);
        send(make_dir(8'd255, 1'b1, 1'b1, 16'sd0, 16'sd0));
        send(make_tick(-16'sd5, 16'sd2000, 16'sd100));
        settle();
        cfg_wr(gtg_pkg::REG_TIMEOUT, 16'd0);
        send(make_tick(16'sd0, 16'sd0, 16'sd0));
        settle();
    endtask

    task automatic test_zero_period();
        cfg_wr(gtg_pkg::REG_TICK_PERIOD, 16'd0);
        cfg_wr(REG_SPARE_A, 16'hffff);
        cfg_wr(REG_SPARE_B, 16'h0000);
        send(make_dir(8'd255, 1'b1, 1'b0, 16'sd3000, -16'sd40));
        send(make_tick(16'sd0, 16'sd0, 16'sd0));
        send(make_tick(16'sd2000, 16'sd900, 16'sd4000));
        send(make_tick(16'sd3000, -16'sd40, 16'sd0));
        settle();
        cfg_wr(gtg_pkg::REG_TICK_PERIOD, 16'd1023);
        send(make_tick(16'sd0, 16'sd0, 16'sd0));
        settle();
    endtask

    task automatic test_random_traffic();
        request_t r;
        logic signed [15:0] ox, oy;
        int pick;
        for (int ph = 0; ph < 8; ph++)
        begin
            idle_off = (ph == 3);
            cfg_wr(gtg_pkg::REG_ROBOT_NUMBER, 16'($urandom_range(0, 255)));
            cfg_wr(gtg_pkg::REG_START_X, rand_coord());
            cfg_wr(gtg_pkg::REG_START_Y, rand_coord());
            cfg_wr(gtg_pkg::REG_LINK_CHECK, 16'($urandom_range(0, 1)));
            cfg_wr(gtg_pkg::REG_TICK_PERIOD, 16'($urandom_range(1, 1000)));
            cfg_wr(gtg_pkg::REG_TIMEOUT, (ph == 5) ? 16'($urandom) :
                                         16'(step_ms * $urandom_range(1, 6)));
            for (int n = 0; n < 125; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    r = make_dir(my_id, 1'b1, 1'($urandom), rand_coord(), rand_coord());
                else if (pick == 3)
                    r = make_dir(8'($urandom), 1'($urandom), 1'($urandom),
                                 16'($urandom), 16'($urandom));
                else
                begin
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            ox = 16'($signed($urandom_range(0, 140)) - 70);
                            oy = 16'($signed($urandom_range(0, 140)) - 70);
                        end
                        1:
                        begin
                            ox = 16'($signed($urandom_range(0, 2200)) - 1100);
                            oy = 16'($signed($urandom_range(0, 2200)) - 1100);
                        end
                        default:
                        begin
                            ox = 16'($urandom);
                            oy = 16'($urandom);
                        end
                    endcase
                    r = make_tick(tgt_x - ox, tgt_y - oy, rand_heading());
                end
                send(r);
                if (ph == 6 && n == 60) settle();
            end
            settle();
        end
        idle_off = 1'b0;
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        idle_off = 1'b0;
        my_id = 8'd0;
        home_x = '0;
        home_y = '0;
        tgt_x = '0;
        tgt_y = '0;
        guard_on = 1'b0;
        heard = 1'b0;
        pend = 1'b0;
        grace_ms = 16'd500;
        step_ms = 10'd100;
        clock_ms = '0;
        last_ms = '0;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        action <= gtg_pkg::ACT_DIRECTIVE;
        well_formed <= 1'b0;
        addressed_robot <= '0;
        link_blocked <= 1'b0;
        directive_x <= '0;
        directive_y <= '0;
        position_x <= '0;
        position_y <= '0;
        heading <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_link();
        test_directed_steering();
        test_zero_period();
        test_random_traffic();
        settle();
        if (errors == 0)
            $display("PASS go_to_goal_steer_with_link_watchdog_unit");
        else
            $display("FAIL go_to_goal_steer_with_link_watchdog_unit");
        $finish;
    end

endmodule
